// ===== rtl/core/kwrf_pkg.sv =====
// shared types, constants and helper functions for the keyword redaction filter
package kwrf_pkg;

   localparam int WinDepth    = 31;
   localparam int FillW       = 5;
   localparam int MaxMsgBytes = 64;
   localparam int CountW      = 7;
   localparam int AddrW       = 6;
   localparam int NoticeLen   = 10;
   localparam int NoticeIdxW  = 4;
   localparam int MarkerCount = 10;
   localparam int MarkerBits  = WinDepth * 8;

   localparam logic [FillW-1:0]  WinFull   = FillW'(WinDepth);
   localparam logic [CountW-1:0] CountMax  = CountW'(MaxMsgBytes);
   localparam logic [CountW-1:0] NoticeCnt = CountW'(NoticeLen);
   localparam logic [CountW-1:0] CutCount  = CountW'(MaxMsgBytes - NoticeLen);

   // marker text sits right aligned, first character in the highest used byte
   localparam logic [MarkerBits-1:0] MarkerText [MarkerCount] = '{
      MarkerBits'("authorization"),
      MarkerBits'("bearer"),
      MarkerBits'("basic"),
      MarkerBits'("password"),
      MarkerBits'("token"),
      MarkerBits'({"ca_", "certificate", "_pem"}),
      MarkerBits'("-----begin certificate-----"),
      MarkerBits'("-----begin private key-----"),
      MarkerBits'("-----begin rsa private key-----"),
      MarkerBits'("-----begin ec private key-----")
   };

   localparam int MarkerLen [MarkerCount] = '{13, 6, 5, 8, 5, 18, 27, 27, 31, 30};

   localparam logic [7:0] NoticeText [NoticeLen] = '{
      8'h5B, 8'h52, 8'h45, 8'h44, 8'h41, 8'h43, 8'h54, 8'h45, 8'h44, 8'h5D
   };

   typedef enum logic [1:0] {
      ST_SCAN,
      ST_DRAIN,
      ST_READ,
      ST_SEND
   } kwrf_state_type;

   typedef struct packed {
      logic load_new;
      logic shift;
   } kwrf_cell_ctl_type;

   function automatic logic [7:0] fold_case(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

   function automatic logic [7:0] clean_byte(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b < 8'h20 || b == 8'h7F) begin
         r = 8'h20;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/kwrf_cell.sv =====
// one window cell: holds a byte, loads a new byte or takes its right neighbor's
module kwrf_cell (
   input  logic                      clock,
   input  kwrf_pkg::kwrf_cell_ctl_type ctl,
   input  logic [7:0]                new_byte,
   input  logic [7:0]                next_byte,
   output logic [7:0]                cur_byte,
   output logic [7:0]                fold_byte
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (ctl.shift) begin
         byte_in = next_byte;
      end else if (ctl.load_new) begin
         byte_in = new_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cur_byte  = byte_ff;
   assign fold_byte = kwrf_pkg::fold_case(byte_ff);

endmodule

// ===== rtl/core/kwrf_match.sv =====
// compares the front of the window against every marker that fits in it
module kwrf_match (
   input  logic [7:0]                 win_fold [kwrf_pkg::WinDepth],
   input  logic [kwrf_pkg::FillW-1:0] fill,
   output logic                       hit
);

   logic [kwrf_pkg::MarkerCount-1:0] mk_hit;

   for (genvar m = 0; m < kwrf_pkg::MarkerCount; m++) begin : g_mk
      logic [kwrf_pkg::WinDepth-1:0] eq;
      for (genvar i = 0; i < kwrf_pkg::WinDepth; i++) begin : g_pos
         if (i < kwrf_pkg::MarkerLen[m]) begin : g_cmp
            assign eq[i] = win_fold[i] ==
               kwrf_pkg::MarkerText[m][(kwrf_pkg::MarkerLen[m]-1-i)*8 +: 8];
         end else begin : g_pad
            assign eq[i] = 1'b1;
         end
      end
      assign mk_hit[m] = (&eq) && (fill >= kwrf_pkg::FillW'(kwrf_pkg::MarkerLen[m]));
   end

   assign hit = |mk_hit;

endmodule

// ===== rtl/core/keyword_redaction_filter.sv =====
// top level: window cell chain, marker matcher, output store and emit sequencer
// flow: after the last item the window drains, judging each remaining byte,
//   then each result is read from the store and then sent
// throughput: 1 item per cycle in scan until the 31-cell window fills, then
//   input pauses while each front byte is judged in a cycle of its own
// reset: synchronous, active high; clears state, window fill, counts and flags only
module keyword_redaction_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [14:8] out_length, [15] zero
   output logic [2:0]  rsp_tuser,   // [0] out_valid, [1] redacted, [2] truncated
   output logic        rsp_tlast
);

   kwrf_pkg::kwrf_state_type state_ff, state_in;

   logic [kwrf_pkg::FillW-1:0]  fill_ff, fill_in;
   logic [kwrf_pkg::CountW-1:0] count_ff, count_in;
   logic [kwrf_pkg::AddrW-1:0]  k_ff, k_in;
   logic redact_ff, redact_in, trunc_ff, trunc_in, stop_ff, stop_in;

   logic [7:0] mem [kwrf_pkg::MaxMsgBytes];
   logic [7:0] rd_ff;

   logic [7:0] win_byte [kwrf_pkg::WinDepth];
   logic [7:0] win_fold [kwrf_pkg::WinDepth];
   kwrf_pkg::kwrf_cell_ctl_type cell_ctl [kwrf_pkg::WinDepth];

   logic req_acc, rsp_acc, push, judge, hit, append, last_res, notice_sel;
   logic [kwrf_pkg::CountW-1:0]     n_out;
   logic [kwrf_pkg::NoticeIdxW-1:0] notice_idx;
   logic [kwrf_pkg::AddrW-1:0]      notice_off;
   logic [7:0] out_byte;

   // window cell chain
   for (genvar i = 0; i < kwrf_pkg::WinDepth; i++) begin : g_cell
      logic [7:0] nb;
      if (i == kwrf_pkg::WinDepth - 1) begin : g_end
         assign nb = win_byte[i];
      end else begin : g_mid
         assign nb = win_byte[i+1];
      end
      assign cell_ctl[i] = '{load_new: push && (fill_ff == kwrf_pkg::FillW'(i)),
                             shift: append};
      kwrf_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[i]),
         .new_byte  (req_tdata),
         .next_byte (nb),
         .cur_byte  (win_byte[i]),
         .fold_byte (win_fold[i])
      );
   end

   kwrf_match u_match (
      .win_fold (win_fold),
      .fill     (fill_ff),
      .hit      (hit)
   );

   // handshake and judge control
   always_comb begin
      req_tready = (state_ff == kwrf_pkg::ST_SCAN) && (fill_ff != kwrf_pkg::WinFull);
      rsp_tvalid = (state_ff == kwrf_pkg::ST_SEND);
      judge = ((state_ff == kwrf_pkg::ST_SCAN) && (fill_ff == kwrf_pkg::WinFull))
           || ((state_ff == kwrf_pkg::ST_DRAIN) && !stop_ff && (fill_ff != '0));
   end

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign push    = req_acc && req_tuser && !stop_ff;
   assign append  = judge && !hit && (count_ff < kwrf_pkg::CountMax);
   assign n_out   = redact_ff ? count_ff + kwrf_pkg::NoticeCnt : count_ff;
   assign last_res = ({1'b0, k_ff} + 7'd1 >= n_out);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kwrf_pkg::ST_SCAN: begin
            if (req_acc && req_tlast) begin
               state_in = kwrf_pkg::ST_DRAIN;
            end
         end
         kwrf_pkg::ST_DRAIN: begin
            if (stop_ff || fill_ff == '0) begin
               state_in = kwrf_pkg::ST_READ;
            end
         end
         kwrf_pkg::ST_READ: begin
            state_in = kwrf_pkg::ST_SEND;
         end
         kwrf_pkg::ST_SEND: begin
            if (rsp_acc) begin
               state_in = last_res ? kwrf_pkg::ST_SCAN : kwrf_pkg::ST_READ;
            end
         end
         default: state_in = kwrf_pkg::ST_SCAN;
      endcase
   end

   // datapath control registers
   always_comb begin
      fill_in   = fill_ff;
      count_in  = count_ff;
      k_in      = k_ff;
      redact_in = redact_ff;
      trunc_in  = trunc_ff;
      stop_in   = stop_ff;
      if (push) begin
         fill_in = fill_ff + 5'd1;
      end
      if (judge) begin
         priority if (hit) begin
            redact_in = 1'b1;
            stop_in   = 1'b1;
            fill_in   = '0;
            if (count_ff + kwrf_pkg::NoticeCnt > kwrf_pkg::CountMax) begin
               count_in = kwrf_pkg::CutCount;
               trunc_in = 1'b1;
            end
         end else if (count_ff >= kwrf_pkg::CountMax) begin
            trunc_in = 1'b1;
            stop_in  = 1'b1;
            fill_in  = '0;
         end else begin
            count_in = count_ff + 7'd1;
            fill_in  = fill_ff - 5'd1;
         end
      end
      if (rsp_acc) begin
         if (last_res) begin
            fill_in   = '0;
            count_in  = '0;
            k_in      = '0;
            redact_in = 1'b0;
            trunc_in  = 1'b0;
            stop_in   = 1'b0;
         end else begin
            k_in = k_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= kwrf_pkg::ST_SCAN;
         fill_ff   <= '0;
         count_ff  <= '0;
         k_ff      <= '0;
         redact_ff <= 1'b0;
         trunc_ff  <= 1'b0;
         stop_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         count_ff  <= count_in;
         k_ff      <= k_in;
         redact_ff <= redact_in;
         trunc_ff  <= trunc_in;
         stop_ff   <= stop_in;
      end
   end

   // output store
   always_ff @(posedge clock) begin
      if (append) begin
         mem[count_ff[kwrf_pkg::AddrW-1:0]] <= kwrf_pkg::clean_byte(win_byte[0]);
      end
      rd_ff <= mem[k_ff];
   end

   // notice bytes follow the stored bytes and come from the constant
   assign notice_sel = redact_ff && ({1'b0, k_ff} >= count_ff);
   assign notice_off = k_ff - count_ff[kwrf_pkg::AddrW-1:0];
   assign notice_idx = notice_off[kwrf_pkg::NoticeIdxW-1:0];

   always_comb begin
      out_byte = rd_ff;
      if (n_out == '0) begin
         out_byte = 8'h00;
      end else if (notice_sel) begin
         out_byte = (notice_idx < kwrf_pkg::NoticeIdxW'(kwrf_pkg::NoticeLen))
                  ? kwrf_pkg::NoticeText[notice_idx] : 8'h00;
      end
   end

   assign rsp_tdata = {1'b0, n_out, out_byte};
   assign rsp_tuser = {trunc_ff, redact_ff, (n_out != '0)};
   assign rsp_tlast = last_res;

`ifndef ASSERT_OFF
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= kwrf_pkg::WinFull) else $error("window fill out of range");
   a_stop_empty: assert property (@(posedge clock) disable iff (reset)
      stop_ff |-> fill_ff == '0) else $error("stopped scan with filled window");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      n_out <= kwrf_pkg::CountMax) else $error("output length beyond maximum");
   a_no_push_judge: assert property (@(posedge clock) disable iff (reset)
      !(push && judge)) else $error("push and judge in one cycle");
   a_end_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_tlast |=> count_ff == '0 && !stop_ff)
      else $error("state not cleared after message");
`endif

endmodule
